>>> rtl/kwsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kwsa_pkg
// Shared types and constants of the keyed weather statistics aggregator.
// ----------------------------------------------------------------------------
package kwsa_pkg;

  localparam int unsigned CODE_W  = 16;
  localparam int unsigned RSLOT_W = 6;
  localparam int unsigned TMS_W   = 44;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned CKEL_W  = 16;
  localparam int unsigned TEMP_W  = 20;
  localparam int unsigned SECS_W  = 35;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned TSUM_W  = 52;
  localparam int unsigned PSUM_W  = 39;
  localparam int unsigned EV_W    = 64;
  localparam int unsigned STAT_W  = 3;

  // Seconds are (ms >> 3) / 125, done as long division a few bits per cycle.
  localparam int unsigned DIV_W      = 48;
  localparam int unsigned DIV_STEP   = 8;
  localparam int unsigned DIV_CYCLES = DIV_W / DIV_STEP;
  localparam int unsigned DIV_CNT_W  = 3;
  localparam logic [7:0]  DIVISOR    = 8'd125;

  localparam logic [20:0] TEMP_MUL    = 21'd9;
  localparam logic [20:0] TEMP_OFFSET = 21'd229835;

  localparam logic        CMD_ACC  = 1'b0;
  localparam logic        CMD_READ = 1'b1;

  localparam logic [STAT_W-1:0] ST_UPDATED = 3'd0;
  localparam logic [STAT_W-1:0] ST_NEW     = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STAT_W-1:0] ST_READ_OK = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd4;

  typedef struct packed {
    logic                   cmd;
    logic [CODE_W-1:0]      code;
    logic [RSLOT_W-1:0]     rslot;
    logic [SECS_W-1:0]      secs;
    logic [PCT_W-1:0]       hum;
    logic                   snow;
    logic [PCT_W-1:0]       cloud;
    logic                   light;
    logic signed [TEMP_W-1:0] temp;
  } item_t;

  typedef struct packed {
    logic [CODE_W-1:0]        code;
    logic [CNT_W-1:0]         count;
    logic signed [TSUM_W-1:0] tsum;
    logic [PSUM_W-1:0]        hsum;
    logic [PSUM_W-1:0]        csum;
    logic signed [TEMP_W-1:0] hi_temp;
    logic [SECS_W-1:0]        max_time;
    logic signed [TEMP_W-1:0] lo_temp;
    logic [SECS_W-1:0]        min_time;
    logic [EV_W-1:0]          ev;
  } entry_t;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_t;
  typedef enum logic [2:0] {B_IDLE, B_SCAN, B_LOAD, B_UPD, B_OUT} back_state_t;

  function automatic entry_t fresh_entry(input item_t it);
    entry_t e;
    e          = '0;
    e.code     = it.code;
    e.hi_temp  = it.temp;
    e.max_time = it.secs;
    e.lo_temp  = it.temp;
    e.min_time = it.secs;
    return e;
  endfunction

endpackage
`default_nettype wire

>>> rtl/keyed_weather_stats_aggregator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_weather_stats_aggregator_top
// Per-region weather statistics table keyed by a two-letter region code.
// ----------------------------------------------------------------------------
// Each input item either accumulates one observation (tuser 0) or reads one
// table slot (tuser 1), and each gives exactly one result item whose tuser is
// the status. The front takes an item, converts the temperature to 1/500 F
// and divides milliseconds to seconds, taking one item at a time through an
// accept state, division steps of 8 quotient bits each and a hand-off state
// that waits for the queue; a two-entry queue then hands the item to the back.
// The back reads the slot memory through a registered read port beside its
// write port. A read goes through a load state to the output state, or
// straight to it for an empty slot; an accumulate scans the allocated slots
// in order, one per cycle, then updates a matching or newly allocated slot,
// or reports a full table. The output state holds until the result is taken.
// Front and back work on different items at once, so the slower of the two
// sets the rate. Slots are allocated in order, so a slot is valid when its
// number is below the fill count; no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module keyed_weather_stats_aggregator_top #(
  parameter int unsigned ENTRIES = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // region_code, read_slot, time_ms, humidity_pct, snow_flag, cloud_pct,
  // lightning_flag, temp_centikelvin (from bit 0 up), zero fill
  input  wire logic [103:0] s_tdata,
  // cmd
  input  wire logic         s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // slot, slot_code, record_count, temp_sum, humidity_sum, cloud_sum,
  // hi_temp, max_time_s, lo_temp, min_time_s, weather_counts, zero fill
  output logic [359:0]      m_tdata,
  // status
  output logic [2:0]        m_tuser
);
  import kwsa_pkg::*;

  logic  push_valid, push_ready, pop_valid, pop;
  item_t push_item, pop_item;

  // Accept and pre-process items.
  kwsa_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .push_valid, .push_ready, .push_item
  );

  // Decouple front and back.
  kwsa_queue u_queue (
    .clk, .rst, .push_valid, .push_ready, .push_item,
    .pop_valid, .pop, .pop_item
  );

  // Look up, update and report.
  kwsa_back #(.ENTRIES(ENTRIES)) u_back (
    .clk, .rst, .pop_valid, .pop, .pop_item,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

endmodule
`default_nettype wire

>>> rtl/kwsa_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kwsa_front
// Accepts items, converts temperature and divides milliseconds to seconds.
// ----------------------------------------------------------------------------
module kwsa_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [103:0]        s_tdata,
  input  wire logic                s_tuser,
  output logic                     push_valid,
  input  wire logic                push_ready,
  output kwsa_pkg::item_t          push_item
);
  import kwsa_pkg::*;

  front_state_t state, state_next;
  item_t        item;
  logic [DIV_W-1:0]     dsr;
  logic [6:0]           rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     dsr_next;
  logic [6:0]           rem_next;
  logic [20:0]          t21;

  assign t21 = 21'(s_tdata[97:82]) * TEMP_MUL - TEMP_OFFSET;

  // One block of restoring division steps per cycle.
  always_comb begin
    logic [7:0] r8;
    dsr_next = dsr;
    rem_next = rem;
    for (int k = 0; k < DIV_STEP; k++) begin
      r8       = {rem_next, dsr_next[DIV_W-1]};
      dsr_next = {dsr_next[DIV_W-2:0], (r8 >= DIVISOR)};
      rem_next = (r8 >= DIVISOR) ? 7'(r8 - DIVISOR) : r8[6:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (s_tvalid) state_next = F_DIV;
      F_DIV:  if (cnt == DIV_CNT_W'(DIV_CYCLES - 1)) state_next = F_PUSH;
      F_PUSH: if (push_ready) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = (state == F_IDLE);
    push_valid = (state == F_PUSH);
    push_item  = item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == F_DIV) cnt <= cnt + 1'b1;
      else                cnt <= '0;
    end
    if (state == F_IDLE && s_tvalid) begin
      item.cmd   <= s_tuser;
      item.code  <= s_tdata[15:0];
      item.rslot <= s_tdata[21:16];
      item.secs  <= '0;
      item.hum   <= s_tdata[72:66];
      item.snow  <= s_tdata[73];
      item.cloud <= s_tdata[80:74];
      item.light <= s_tdata[81];
      item.temp  <= t21[TEMP_W-1:0];
      dsr        <= DIV_W'(s_tdata[65:25]);
      rem        <= '0;
    end else if (state == F_DIV) begin
      dsr <= dsr_next;
      rem <= rem_next;
      if (cnt == DIV_CNT_W'(DIV_CYCLES - 1)) item.secs <= dsr_next[SECS_W-1:0];
    end
  end

endmodule
`default_nettype wire

>>> rtl/kwsa_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kwsa_queue
// Two-entry queue of items between front and back.
// ----------------------------------------------------------------------------
module kwsa_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire kwsa_pkg::item_t push_item,
  output logic                 pop_valid,
  input  wire logic            pop,
  output kwsa_pkg::item_t      pop_item
);
  import kwsa_pkg::*;

  item_t      buf_q [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;
  logic       do_push, do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_item   = buf_q[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(do_push) - 2'(do_pop);
    end
    if (do_push) buf_q[wr_ptr] <= push_item;
  end

endmodule
`default_nettype wire

>>> rtl/kwsa_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kwsa_back
// Looks up slots, updates the statistics table and forms results.
// ----------------------------------------------------------------------------
module kwsa_back #(
  parameter int unsigned ENTRIES = 64
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            pop_valid,
  output logic                 pop,
  input  wire kwsa_pkg::item_t pop_item,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [359:0]         m_tdata,
  output logic [2:0]           m_tuser
);
  import kwsa_pkg::*;

  localparam int unsigned AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned NFW = $clog2(ENTRIES + 1);
  localparam int unsigned CW  = (NFW > RSLOT_W) ? NFW : RSLOT_W;

  back_state_t state, state_next;
  item_t       cur;
  entry_t      base, upd, rdata;
  entry_t      mem [ENTRIES];
  logic [AW-1:0]  idx, slot_r, rd_addr;
  logic [NFW-1:0] next_free;
  logic [STAT_W-1:0]  st_r, res_status;
  logic [RSLOT_W-1:0] res_slot;
  entry_t      res_entry;
  logic        we;
  logic        read_hit, alloc_ok, match, more;

  assign read_hit = CW'(pop_item.rslot) < CW'(next_free);
  assign alloc_ok = next_free < NFW'(ENTRIES);
  assign match    = (rdata.code == cur.code);
  assign more     = (NFW'(idx) + 1'b1) < next_free;

  // Update one slot with the current record, saturating every counter.
  always_comb begin
    logic signed [TSUM_W:0] ts;
    logic [PSUM_W:0] hs, cs;
    logic [31:0] lc, sc;
    upd   = base;
    upd.count = (&base.count) ? base.count : base.count + 1'b1;
    ts = {base.tsum[TSUM_W-1], base.tsum} + (TSUM_W+1)'(cur.temp);
    if (ts[TSUM_W] != ts[TSUM_W-1])
      upd.tsum = ts[TSUM_W] ? {1'b1, {(TSUM_W-1){1'b0}}} : {1'b0, {(TSUM_W-1){1'b1}}};
    else
      upd.tsum = ts[TSUM_W-1:0];
    hs = {1'b0, base.hsum} + (PSUM_W+1)'(cur.hum);
    cs = {1'b0, base.csum} + (PSUM_W+1)'(cur.cloud);
    upd.hsum = hs[PSUM_W] ? '1 : hs[PSUM_W-1:0];
    upd.csum = cs[PSUM_W] ? '1 : cs[PSUM_W-1:0];
    if (cur.temp > base.hi_temp) begin
      upd.hi_temp  = cur.temp;
      upd.max_time = cur.secs;
    end
    if (cur.temp < base.lo_temp) begin
      upd.lo_temp  = cur.temp;
      upd.min_time = cur.secs;
    end
    lc = base.ev[63:32];
    sc = base.ev[31:0];
    if (cur.light && !(&lc)) lc = lc + 1'b1;
    if (cur.snow && !(&sc))  sc = sc + 1'b1;
    upd.ev = {lc, sc};
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (pop_valid) begin
          if (pop_item.cmd == CMD_READ)  state_next = read_hit ? B_LOAD : B_OUT;
          else if (next_free == '0)      state_next = alloc_ok ? B_UPD : B_OUT;
          else                           state_next = B_SCAN;
        end
      end
      B_SCAN: begin
        if (match)         state_next = B_UPD;
        else if (!more)    state_next = alloc_ok ? B_UPD : B_OUT;
      end
      B_LOAD: state_next = B_OUT;
      B_UPD:  state_next = B_OUT;
      B_OUT:  if (m_tready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop      = (state == B_IDLE);
    m_tvalid = (state == B_OUT);
    we       = (state == B_UPD);
    unique case (state)
      B_IDLE:  rd_addr = (pop_item.cmd == CMD_READ) ? AW'(pop_item.rslot) : '0;
      B_SCAN:  rd_addr = idx + 1'b1;
      default: rd_addr = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[slot_r] <= upd;
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      next_free <= '0;
    end else begin
      state <= state_next;
      if ((state == B_IDLE && pop_valid && pop_item.cmd == CMD_ACC &&
           next_free == '0 && alloc_ok) ||
          (state == B_SCAN && !match && !more && alloc_ok))
        next_free <= next_free + 1'b1;
    end
    unique case (state)
      B_IDLE: begin
        if (pop_valid) begin
          cur    <= pop_item;
          idx    <= '0;
          base   <= fresh_entry(pop_item);
          slot_r <= '0;
          st_r   <= ST_NEW;
          res_entry <= '0;
          if (pop_item.cmd == CMD_READ) begin
            res_status <= ST_EMPTY;
            res_slot   <= pop_item.rslot;
          end else begin
            res_status <= ST_FULL;
            res_slot   <= '0;
          end
        end
      end
      B_SCAN: begin
        if (match) begin
          base   <= rdata;
          slot_r <= idx;
          st_r   <= ST_UPDATED;
        end else if (more) begin
          idx <= idx + 1'b1;
        end else begin
          base   <= fresh_entry(cur);
          slot_r <= AW'(next_free);
          st_r   <= ST_NEW;
        end
      end
      B_LOAD: begin
        res_status <= ST_READ_OK;
        res_slot   <= cur.rslot;
        res_entry  <= rdata;
      end
      B_UPD: begin
        res_status <= st_r;
        res_slot   <= RSLOT_W'(slot_r);
        res_entry  <= upd;
      end
      default: ;
    endcase
  end

  assign m_tuser = res_status;
  assign m_tdata = {2'b00, res_entry.ev, res_entry.min_time, res_entry.lo_temp,
                    res_entry.max_time, res_entry.hi_temp, res_entry.csum,
                    res_entry.hsum, res_entry.tsum, res_entry.count,
                    res_entry.code, res_slot};

endmodule
`default_nettype wire
